### rtl/rmd_pkg.sv
// Package for the running median deviation unit: sizes, state codes and control structs.
`default_nettype none
package rmd_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  localparam int VAL_W    = 32;
  localparam int SUM_W    = 38;
  localparam int MED_W    = 33;
  localparam int DEV_W    = 39;
  localparam int OCNT_W   = 7;
  localparam int OUT_W    = 80;

  localparam logic CMD_CLEAR  = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } rmd_state_e;

  typedef struct packed {
    logic ins;
    logic clr;
    logic load;
    logic shift;
  } rmd_cell_ctrl_t;

  typedef struct packed {
    logic start;
    logic step;
  } rmd_scan_ctrl_t;

endpackage
`default_nettype wire

### rtl/rmd_cell.sv
// One cell of the sorted-insert chain: a stored sample plus a scan-out shift stage.
`default_nettype none
module rmd_cell (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire rmd_pkg::rmd_cell_ctrl_t            ctrl_i,
  input  wire logic signed [rmd_pkg::VAL_W-1:0]   x_i,
  input  wire logic signed [rmd_pkg::VAL_W-1:0]   left_val_i,
  input  wire logic                               left_gt_i,
  input  wire logic                               left_occ_i,
  input  wire logic signed [rmd_pkg::VAL_W-1:0]   scan_i,
  output logic signed [rmd_pkg::VAL_W-1:0]        val_o,
  output logic                                    gt_o,
  output logic                                    occ_o,
  output logic signed [rmd_pkg::VAL_W-1:0]        scan_o
);

  logic signed [rmd_pkg::VAL_W-1:0] val_q, val_d;
  logic signed [rmd_pkg::VAL_W-1:0] scan_q, scan_d;
  logic                             occ_q, occ_d;
  logic                             gt;
  logic                             take;

  // strict compare: an equal sample lands after the ones already held
  assign gt   = occ_q && (val_q > x_i);
  assign take = ctrl_i.ins && (gt || (!occ_q && left_occ_i));

  always_comb begin
    val_d = take ? (left_gt_i ? left_val_i : x_i) : val_q;
    if (ctrl_i.clr) begin
      occ_d = 1'b0;
    end else if (ctrl_i.ins) begin
      occ_d = occ_q | left_occ_i;
    end else begin
      occ_d = occ_q;
    end
    if (ctrl_i.load) begin
      scan_d = val_d;
    end else if (ctrl_i.shift) begin
      scan_d = scan_i;
    end else begin
      scan_d = scan_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    scan_q <= scan_d;
  end

  assign val_o  = val_q;
  assign gt_o   = gt;
  assign occ_o  = occ_q;
  assign scan_o = scan_q;

endmodule
`default_nettype wire

### rtl/rmd_scan.sv
// Scan accumulator: sums lower and upper halves and the doubled median as samples stream out.
`default_nettype none
module rmd_scan (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire rmd_pkg::rmd_scan_ctrl_t            ctrl_i,
  input  wire logic [rmd_pkg::CNT_W-1:0]          count_i,
  input  wire logic signed [rmd_pkg::VAL_W-1:0]   sample_i,
  output logic                                    done_o,
  output logic signed [rmd_pkg::SUM_W-1:0]        lo_o,
  output logic signed [rmd_pkg::SUM_W-1:0]        hi_o,
  output logic signed [rmd_pkg::MED_W-1:0]        med2_o
);

  logic [rmd_pkg::IDX_W-1:0]         k_q, k_d;
  logic signed [rmd_pkg::SUM_W-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic signed [rmd_pkg::MED_W-1:0]  med_q, med_d;
  logic [rmd_pkg::CNT_W-1:0]         kk;
  logic [rmd_pkg::CNT_W-1:0]         half;
  logic                              is_lower, is_upper, is_mid;
  logic signed [rmd_pkg::SUM_W-1:0]  s_sum;
  logic signed [rmd_pkg::MED_W-1:0]  s_med;

  assign kk     = rmd_pkg::CNT_W'(k_q);
  assign half   = count_i >> 1;
  assign done_o = (kk == count_i - 1'b1);

  assign is_lower = kk < half;
  assign is_upper = kk >= (count_i - half);
  assign is_mid   = count_i[0] ? (kk == half) : ((kk == half) || (kk == half - 1'b1));

  assign s_sum = {{(rmd_pkg::SUM_W-rmd_pkg::VAL_W){sample_i[rmd_pkg::VAL_W-1]}}, sample_i};
  // odd count: the single middle sample counts twice
  assign s_med = count_i[0] ? {sample_i, 1'b0}
                            : {{(rmd_pkg::MED_W-rmd_pkg::VAL_W){sample_i[rmd_pkg::VAL_W-1]}},
                               sample_i};

  always_comb begin
    k_d   = k_q;
    lo_d  = lo_q;
    hi_d  = hi_q;
    med_d = med_q;
    if (ctrl_i.start) begin
      k_d   = '0;
      lo_d  = '0;
      hi_d  = '0;
      med_d = '0;
    end else if (ctrl_i.step) begin
      k_d = k_q + 1'b1;
      if (is_lower) begin
        lo_d = lo_q + s_sum;
      end
      if (is_upper) begin
        hi_d = hi_q + s_sum;
      end
      if (is_mid) begin
        med_d = med_q + s_med;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else begin
      k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    med_q <= med_d;
  end

  assign lo_o   = lo_q;
  assign hi_o   = hi_q;
  assign med2_o = med_q;

endmodule
`default_nettype wire

### rtl/running_median_deviation_unit.sv
// Top level: sorted-insert cell chain, scan accumulator, control and output register.
//
//  channel   dir  tdata (low bit up)                              tuser
//  s_axis    in   value[31:0]                                     command
//  m_axis    out  median_doubled[32:0], abs_deviation_sum[71:33], insert_refused
//                 element_count[78:72], zero pad[79]
//
// An insert places the sample in the cell chain, shifts the held samples out through the
// single accumulator, then loads the output register. A clear goes straight to loading
// the output register.
// Reset empties the chain through per-cell occupied flags; sample registers are not reset.
// A new request is taken while a finished result still waits; the finish step holds
// until the output register is free.
`default_nettype none
module running_median_deviation_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire logic [rmd_pkg::VAL_W-1:0]   s_axis_tdata_i,  // value
  input  wire logic                        s_axis_tuser_i,  // command
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  output logic [rmd_pkg::OUT_W-1:0]        m_axis_tdata_o,  // median_doubled, abs_deviation_sum,
                                                            // element_count, pad
  output logic                             m_axis_tuser_o   // insert_refused
);

  rmd_pkg::rmd_state_e     state_q, state_d;
  rmd_pkg::rmd_cell_ctrl_t cell_ctrl;
  rmd_pkg::rmd_scan_ctrl_t scan_ctrl;

  logic                        accept;
  logic                        is_insert;
  logic                        full;
  logic                        scan_done;
  logic                        out_load;
  logic [rmd_pkg::CNT_W-1:0]   count_q, count_d;
  logic                        refused_q, refused_d;
  logic                        tvalid_q, tvalid_d;
  logic [rmd_pkg::OUT_W-1:0]   tdata_q;
  logic                        tuser_q;

  logic [rmd_pkg::CAPACITY:0]        gt_w;
  logic [rmd_pkg::CAPACITY:0]        occ_w;
  logic signed [rmd_pkg::VAL_W-1:0]  val_w  [rmd_pkg::CAPACITY+1];
  logic signed [rmd_pkg::VAL_W-1:0]  scan_w [rmd_pkg::CAPACITY+1];

  logic signed [rmd_pkg::SUM_W-1:0]  lo_sum, hi_sum;
  logic signed [rmd_pkg::MED_W-1:0]  med2;
  logic [rmd_pkg::DEV_W-1:0]         dev;

  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign is_insert = (s_axis_tuser_i == rmd_pkg::CMD_INSERT);
  assign full      = (count_q == rmd_pkg::CNT_W'(rmd_pkg::CAPACITY));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rmd_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = is_insert ? rmd_pkg::ST_SCAN : rmd_pkg::ST_FINISH;
        end
      end
      rmd_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = rmd_pkg::ST_FINISH;
        end
      end
      rmd_pkg::ST_FINISH: begin
        if (!tvalid_q || m_axis_tready_i) begin
          state_d = rmd_pkg::ST_IDLE;
        end
      end
      default: state_d = rmd_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    cell_ctrl       = '0;
    scan_ctrl       = '0;
    out_load        = 1'b0;
    case (state_q)
      rmd_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (accept) begin
          cell_ctrl.ins   = is_insert && !full;
          cell_ctrl.clr   = !is_insert;
          cell_ctrl.load  = 1'b1;
          scan_ctrl.start = 1'b1;
        end
      end
      rmd_pkg::ST_SCAN: begin
        cell_ctrl.shift = 1'b1;
        scan_ctrl.step  = 1'b1;
      end
      rmd_pkg::ST_FINISH: begin
        out_load = !tvalid_q || m_axis_tready_i;
      end
      default: begin
        s_axis_tready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_d   = count_q;
    refused_d = refused_q;
    if (accept) begin
      if (!is_insert) begin
        count_d   = '0;
        refused_d = 1'b0;
      end else if (full) begin
        refused_d = 1'b1;
      end else begin
        count_d   = count_q + 1'b1;
        refused_d = 1'b0;
      end
    end
    if (out_load) begin
      tvalid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      tvalid_d = 1'b0;
    end else begin
      tvalid_d = tvalid_q;
    end
  end

  assign gt_w[0]                   = 1'b0;
  assign occ_w[0]                  = 1'b1;
  assign val_w[0]                  = '0;
  assign scan_w[rmd_pkg::CAPACITY] = '0;

  for (genvar i = 0; i < rmd_pkg::CAPACITY; i++) begin : g_cell
    rmd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .x_i        (s_axis_tdata_i),
      .left_val_i (val_w[i]),
      .left_gt_i  (gt_w[i]),
      .left_occ_i (occ_w[i]),
      .scan_i     (scan_w[i+1]),
      .val_o      (val_w[i+1]),
      .gt_o       (gt_w[i+1]),
      .occ_o      (occ_w[i+1]),
      .scan_o     (scan_w[i])
    );
  end

  rmd_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (scan_ctrl),
    .count_i  (count_q),
    .sample_i (scan_w[0]),
    .done_o   (scan_done),
    .lo_o     (lo_sum),
    .hi_o     (hi_sum),
    .med2_o   (med2)
  );

  assign dev = {{(rmd_pkg::DEV_W-rmd_pkg::SUM_W){hi_sum[rmd_pkg::SUM_W-1]}}, hi_sum}
             - {{(rmd_pkg::DEV_W-rmd_pkg::SUM_W){lo_sum[rmd_pkg::SUM_W-1]}}, lo_sum};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rmd_pkg::ST_IDLE;
      count_q   <= '0;
      refused_q <= 1'b0;
      tvalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      refused_q <= refused_d;
      tvalid_q  <= tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      tdata_q <= {1'b0, rmd_pkg::OCNT_W'(count_q), dev, med2};
      tuser_q <= refused_q;
    end
  end

  assign m_axis_tvalid_o = tvalid_q;
  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tuser_o  = tuser_q;

endmodule
`default_nettype wire
